/* rtl/core/assert_macros.svh */
// Assertion macros shared by the port knock detector RTL.
// Used by files that include it by bare name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define PKSD_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When ante holds, cons must hold at the following edge.
`define PKSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/pksd_pkg.sv */
// Package for the port knock detector: widths, register indexes, history
// entry type and the cell/scanner control types. No dependencies.
`timescale 1ns / 1ps

package pksd_pkg;

  localparam int HIST_DEPTH_DEF = 16;
  localparam int SEQ_LEN_DEF    = 5;
  localparam int NUM_SEQ_REGS   = 5;

  localparam int ADDR_W    = 32;
  localparam int PORT_W    = 16;
  localparam int CFG_IDX_W = 3;

  // register index of seq_port_0; seq_port_j sits at CFG_SEQ_PORT_0 + j
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_PORT_0 = 3'd0;

  localparam logic ACT_KNOCK = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } hist_entry_t;

  // what every cell of the history ring does on a clock edge
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_PUSH  = 2'd1,  // take the word from the newer neighbor
    CELL_PULL  = 2'd2,  // take the word from the older neighbor
    CELL_CLEAR = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

endpackage

/* rtl/core/port_knock_sequence_detector.sv */
// Top level of the port knock detector: config registers, history ring of
// pksd_cell, pksd_scan matcher and the control sequencer. Uses pksd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port knock sequence detector.
// in_*  : one word per knock: in_action (0 knock, 1 clear history),
//         in_src_addr, in_dest_port. Valid/ready.
// out_* : one word per input word: out_sequence_ok. Valid/ready.
// cfg_* : register writes, cfg_index 0..4 selects seq_port_0..4, other
//         indexes are dropped. cfg_ready is always high; write only while
//         the block is idle.
// A knock is shifted into the head of a ring of HIST_DEPTH cells, then the
// ring rotates once around past the matcher, newest entry first, which
// leaves the ring in its original order. The result then passes the done
// state into the output register; a full output register can hold it there.
// A word is taken only in the idle state, so a knock is not taken before the
// last one has left the done state. A clear zeroes every cell at once and
// goes straight to the done state with a result of 0.
// The output register lets the next word be accepted while a result waits;
// a finished result that cannot enter the output register holds the block.
// Synchronous reset zeroes the history and the sequence registers.
module port_knock_sequence_detector #(
  parameter int HIST_DEPTH = pksd_pkg::HIST_DEPTH_DEF,
  parameter int SEQ_LEN    = pksd_pkg::SEQ_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [pksd_pkg::ADDR_W-1:0]    in_src_addr,
  input  logic [pksd_pkg::PORT_W-1:0]    in_dest_port,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_sequence_ok,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pksd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pksd_pkg::PORT_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(HIST_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_ok_r, out_ok_nxt;
  logic [pksd_pkg::PORT_W-1:0] seq_r [pksd_pkg::NUM_SEQ_REGS];
  logic [pksd_pkg::PORT_W-1:0] seq_use [SEQ_LEN];

  pksd_pkg::cell_op_t    cell_op;
  pksd_pkg::hist_entry_t knock;
  pksd_pkg::hist_entry_t cell_q [HIST_DEPTH];
  pksd_pkg::scan_ctl_t   scan_ctl;
  logic                  scan_match;
  logic                  in_fire;
  logic                  out_free;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < pksd_pkg::NUM_SEQ_REGS; j++) seq_r[j] <= '0;
    end else if (cfg_valid) begin
      for (int j = 0; j < pksd_pkg::NUM_SEQ_REGS; j++) begin
        if (cfg_index == pksd_pkg::CFG_IDX_W'(pksd_pkg::CFG_SEQ_PORT_0 + j)) begin
          seq_r[j] <= cfg_data;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < SEQ_LEN; j++) seq_use[j] = seq_r[j];
  end

  // ---------------- control ----------------
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    cell_op       = pksd_pkg::CELL_HOLD;
    scan_ctl      = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          scan_ctl.start = 1'b1;
          cnt_nxt        = '0;
          if (in_action == pksd_pkg::ACT_CLEAR) begin
            cell_op   = pksd_pkg::CELL_CLEAR;
            state_nxt = ST_DONE;
          end else begin
            cell_op   = pksd_pkg::CELL_PUSH;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // matcher sees cell 0; the ring rotates older entries toward it
        cell_op       = pksd_pkg::CELL_PULL;
        scan_ctl.step = 1'b1;
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(HIST_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = scan_match;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r <= out_ok_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_sequence_ok = out_ok_r;

  // ---------------- history ring ----------------
  assign knock.addr = in_src_addr;
  assign knock.port = in_dest_port;

  for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
    pksd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (cell_op),
      .newer_i ((k == 0) ? knock : cell_q[(k + HIST_DEPTH - 1) % HIST_DEPTH]),
      .older_i (cell_q[(k + 1) % HIST_DEPTH]),
      .entry_o (cell_q[k])
    );
  end

  pksd_scan #(
    .SEQ_LEN (SEQ_LEN)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .addr_i     (in_src_addr),
    .seq_port_i (seq_use),
    .entry_i    (cell_q[0]),
    .match_o    (scan_match)
  );

  `PKSD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready,
                    "accepted a word while still busy")
  `PKSD_ASSERT_NEXT(a_clear_to_done, clk, rst_n, in_fire && in_action == pksd_pkg::ACT_CLEAR,
                    state_r == ST_DONE, "clear did not finish at once")
  `PKSD_ASSERT(a_cnt_idle, clk, rst_n, state_r == ST_SCAN || cnt_r == '0,
               "rotation count left nonzero")

endmodule

/* rtl/core/pksd_cell.sv */
// One history cell of the port knock detector ring.
// Depends on pksd_pkg.
`timescale 1ns / 1ps

module pksd_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pksd_pkg::cell_op_t   op,
  input  pksd_pkg::hist_entry_t newer_i,
  input  pksd_pkg::hist_entry_t older_i,
  output pksd_pkg::hist_entry_t entry_o
);

  pksd_pkg::hist_entry_t entry_r;
  pksd_pkg::hist_entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (op)
      pksd_pkg::CELL_HOLD:  entry_nxt = entry_r;
      pksd_pkg::CELL_PUSH:  entry_nxt = newer_i;
      pksd_pkg::CELL_PULL:  entry_nxt = older_i;
      pksd_pkg::CELL_CLEAR: entry_nxt = '0;
      default:              entry_nxt = entry_r;
    endcase
  end

  // history is zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry_o = entry_r;

endmodule

/* rtl/core/pksd_scan.sv */
// Sequence matcher: sees one history word per step, newest first, and
// tracks how many sequence ports are still to match. Depends on pksd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pksd_scan #(
  parameter int SEQ_LEN = pksd_pkg::SEQ_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pksd_pkg::scan_ctl_t         ctl,
  input  logic [pksd_pkg::ADDR_W-1:0] addr_i,
  input  logic [pksd_pkg::PORT_W-1:0] seq_port_i [SEQ_LEN],
  input  pksd_pkg::hist_entry_t       entry_i,
  output logic                        match_o
);

  localparam int REM_W = $clog2(SEQ_LEN + 1);

  logic [REM_W-1:0]            rem_r,  rem_nxt;
  logic                        stop_r, stop_nxt;
  logic [pksd_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [pksd_pkg::PORT_W-1:0] want_port;

  // port expected next: seq_port[rem - 1]
  always_comb begin
    want_port = '0;
    for (int j = 0; j < SEQ_LEN; j++) begin
      if (rem_r == REM_W'(j + 1)) want_port = seq_port_i[j];
    end
  end

  always_comb begin
    rem_nxt  = rem_r;
    stop_nxt = stop_r;
    addr_nxt = addr_r;
    if (ctl.start) begin
      rem_nxt  = REM_W'(SEQ_LEN);
      stop_nxt = 1'b0;
      addr_nxt = addr_i;
    end else if (ctl.step && !stop_r && entry_i.addr == addr_r) begin
      if (entry_i.port == want_port) begin
        rem_nxt  = rem_r - REM_W'(1);
        stop_nxt = (rem_r == REM_W'(1));
      end else if (rem_r != REM_W'(SEQ_LEN)) begin
        // mismatch after the match has begun
        stop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= REM_W'(SEQ_LEN);
      stop_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      stop_r <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  assign match_o = (rem_r == '0);

  `PKSD_ASSERT(a_rem_range, clk, rst_n, rem_r <= REM_W'(SEQ_LEN), "remaining count out of range")
  `PKSD_ASSERT(a_done_stops, clk, rst_n, rem_r != '0 || stop_r, "full match did not stop scan")
  `PKSD_ASSERT_NEXT(a_start_fresh, clk, rst_n, ctl.start,
                    rem_r == REM_W'(SEQ_LEN) && !stop_r, "scan did not restart")

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for port_knock_sequence_detector: directed table, then random
// knock sequences under several port settings. Scored by an in-bench predictor, typed rows by
// their own want. Depends on pksd_pkg and the detector RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int HIST_DEPTH_DEF = pksd_pkg::HIST_DEPTH_DEF;
  localparam int SEQ_LEN_DEF    = pksd_pkg::SEQ_LEN_DEF;
  localparam int NUM_SEQ_REGS   = pksd_pkg::NUM_SEQ_REGS;
  localparam int ADDR_W         = pksd_pkg::ADDR_W;
  localparam int PORT_W         = pksd_pkg::PORT_W;
  localparam int CFG_IDX_W      = pksd_pkg::CFG_IDX_W;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_WORDS   = 700;
  localparam int PHASES       = 4;
  localparam int IDLE_PCT     = 38;
  localparam int SETTLE       = HIST_DEPTH_DEF + 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST =
    CFG_IDX_W'(pksd_pkg::CFG_SEQ_PORT_0 + NUM_SEQ_REGS);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST    = {CFG_IDX_W{1'b1}};

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic                   act;
    logic [ADDR_W-1:0]      addr;
    logic [PORT_W-1:0]      port;   // write data for register rows
    logic [CFG_IDX_W-1:0]   idx;
    bit                     typed;
    logic                   want;
  } dir_row_t;

  typedef logic [PORT_W-1:0] port_set_t [NUM_SEQ_REGS];

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_action = pksd_pkg::ACT_KNOCK;
  logic [ADDR_W-1:0]    in_src_addr = '0;
  logic [PORT_W-1:0]    in_dest_port = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_sequence_ok;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PORT_W-1:0]    cfg_data = '0;

  port_knock_sequence_detector dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_src_addr     (in_src_addr),
    .in_dest_port    (in_dest_port),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sequence_ok (out_sequence_ok),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // predictor state: history ring, newest slot and secret sequence
  logic [ADDR_W-1:0] ring_addr [HIST_DEPTH_DEF] = '{default: '0};
  logic [PORT_W-1:0] ring_port [HIST_DEPTH_DEF] = '{default: '0};
  int unsigned       newest = 0;
  port_set_t         secret = '{default: '0};

  logic        pending_ok [$];
  dir_row_t    dir_rows [$];
  logic [ADDR_W-1:0] addr_pool [4];
  bit          calm = 1'b0;
  int          errors = 0;
  int          cycles = 0;
  int          knocks_sent = 0;
  int          clears_sent = 0;
  int          hits = 0;
  int          settings = 0;
  int          rand_words = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycles, pending_ok.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Updates the ring for one word and returns the expected sequence_ok.
  function automatic logic knock_verdict(input logic act, input logic [ADDR_W-1:0] addr,
                                         input logic [PORT_W-1:0] port);
    int unsigned left;
    int unsigned slot;
    if (act == pksd_pkg::ACT_CLEAR) begin
      for (int k = 0; k < HIST_DEPTH_DEF; k++) begin
        ring_addr[k] = '0;
        ring_port[k] = '0;
      end
      return 1'b0;
    end
    newest = (newest + 1) % HIST_DEPTH_DEF;
    ring_addr[newest] = addr;
    ring_port[newest] = port;
    left = SEQ_LEN_DEF;
    // newest to oldest, same address only; sequence is matched back to front
    for (int i = 0; i < HIST_DEPTH_DEF && left > 0; i++) begin
      slot = (newest + HIST_DEPTH_DEF - i) % HIST_DEPTH_DEF;
      if (ring_addr[slot] == addr) begin
        if (ring_port[slot] == secret[(left - 1) % NUM_SEQ_REGS]) left--;
        else if (left < SEQ_LEN_DEF) break;
      end
    end
    return left == 0;
  endfunction

  // result side: score accepted words, then pick next ready
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pending_ok.size() == 0) begin
        report_mismatch($sformatf("sequence_ok=%0b with no word pending", out_sequence_ok));
      end else if (out_sequence_ok !== pending_ok[0]) begin
        report_mismatch($sformatf("sequence_ok got %0b want %0b", out_sequence_ok,
                                  pending_ok[0]));
      end
      if (pending_ok.size() != 0) void'(pending_ok.pop_front());
    end
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_word(input logic act, input logic [ADDR_W-1:0] addr,
                           input logic [PORT_W-1:0] port, input bit typed, input logic want);
    logic predicted;
    if (!calm) begin
      if ($urandom_range(0, 99) < 10) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_src_addr  <= addr;
    in_dest_port <= port;
    do @(posedge clk); while (!in_ready);
    predicted = knock_verdict(act, addr, port);
    pending_ok.push_back(typed ? want : predicted);
    if (predicted) hits++;
    if (act == pksd_pkg::ACT_CLEAR) clears_sent++;
    else knocks_sent++;
  endtask

  // hold off input until every result is back and the block is quiet
  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_ok.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PORT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx - pksd_pkg::CFG_SEQ_PORT_0 < NUM_SEQ_REGS)
      secret[idx - pksd_pkg::CFG_SEQ_PORT_0] = data;
  endtask

  task automatic load_ports(input port_set_t ports);
    drain_words();
    for (int j = 0; j < NUM_SEQ_REGS; j++)
      write_reg(CFG_IDX_W'(pksd_pkg::CFG_SEQ_PORT_0 + j), ports[j]);
    write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_IDX_LAST)), 16'($urandom));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 99) < 20) return $urandom;
    return addr_pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [PORT_W-1:0] pick_port();
    if ($urandom_range(0, 1) == 0) return secret[$urandom_range(0, NUM_SEQ_REGS - 1)];
    return 16'($urandom);
  endfunction

  // Mostly well-formed knock sequences with noise mixed in; some plain noise,
  // clears and cut-off sequences.
  task automatic random_episode();
    logic [ADDR_W-1:0] a;
    int                kind;
    int                stop_at;
    int                r;
    a       = pick_addr();
    kind    = $urandom_range(0, 99);
    stop_at = SEQ_LEN_DEF;
    if (kind >= 93) stop_at = $urandom_range(1, SEQ_LEN_DEF - 1);
    if (kind < 60 || kind >= 93) begin
      for (int j = 0; j < stop_at; j++) begin
        r = $urandom_range(0, 99);
        if (r < 20)
          send_word(pksd_pkg::ACT_KNOCK, a ^ ($urandom | 32'h1), pick_port(), 1'b0, 1'b0);
        else if (r < 26)
          send_word(pksd_pkg::ACT_KNOCK, a, 16'($urandom), 1'b0, 1'b0);
        else if (r < 29)
          send_word(pksd_pkg::ACT_CLEAR, $urandom, 16'($urandom), 1'b0, 1'b0);
        send_word(pksd_pkg::ACT_KNOCK, a, secret[j], 1'b0, 1'b0);
      end
      // a later knock from the same source can still see the old sequence
      if ($urandom_range(0, 99) < 30)
        send_word(pksd_pkg::ACT_KNOCK, a, pick_port(), 1'b0, 1'b0);
    end else if (kind < 85) begin
      send_word(pksd_pkg::ACT_KNOCK, a, pick_port(), 1'b0, 1'b0);
    end else begin
      send_word(pksd_pkg::ACT_CLEAR, $urandom, 16'($urandom), 1'b0, 1'b0);
    end
    rand_words = knocks_sent + clears_sent;
  endtask

  function automatic void word_row(input logic act, input logic [ADDR_W-1:0] addr,
                                   input logic [PORT_W-1:0] port, input bit typed,
                                   input logic want);
    dir_rows.push_back('{ROW_WORD, act, addr, port, '0, typed, want});
  endfunction

  function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [PORT_W-1:0] data);
    dir_rows.push_back('{ROW_REG, pksd_pkg::ACT_KNOCK, '0, data, idx, 1'b0, 1'b0});
  endfunction

  initial begin
    port_set_t ports;
    int        base;

    // reset sequence is all zero: a zero knock on the zeroed history completes it
    word_row(pksd_pkg::ACT_KNOCK, 32'h0000_0000, 16'h0000, 1'b1, 1'b1);
    word_row(pksd_pkg::ACT_KNOCK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
    word_row(pksd_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
    word_row(pksd_pkg::ACT_KNOCK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
    word_row(pksd_pkg::ACT_KNOCK, 32'h0000_0000, 16'h0000, 1'b1, 1'b1);
    for (int j = 0; j < NUM_SEQ_REGS; j++)
      reg_row(CFG_IDX_W'(pksd_pkg::CFG_SEQ_PORT_0 + j), 16'(100 * (j + 1)));
    reg_row(CFG_SPARE_FIRST, 16'hFFFF);
    reg_row(CFG_IDX_LAST, 16'h0000);
    // full sequence with another source interleaved
    word_row(pksd_pkg::ACT_KNOCK, 32'h0A00_0001, 16'd100, 1'b0, 1'b0);
    word_row(pksd_pkg::ACT_KNOCK, 32'h0A00_0002, 16'd100, 1'b0, 1'b0);
    word_row(pksd_pkg::ACT_KNOCK, 32'h0A00_0001, 16'd200, 1'b0, 1'b0);
    word_row(pksd_pkg::ACT_KNOCK, 32'h0A00_0001, 16'd300, 1'b0, 1'b0);
    word_row(pksd_pkg::ACT_KNOCK, 32'h0A00_0001, 16'd400, 1'b0, 1'b0);
    word_row(pksd_pkg::ACT_KNOCK, 32'h0A00_0001, 16'd500, 1'b1, 1'b1);
    word_row(pksd_pkg::ACT_KNOCK, 32'h0A00_0001, 16'd7777, 1'b0, 1'b0);
    // wrong port once the match has begun ends the scan
    word_row(pksd_pkg::ACT_KNOCK, 32'h0A00_0001, 16'd9, 1'b0, 1'b0);
    word_row(pksd_pkg::ACT_KNOCK, 32'h0A00_0001, 16'd500, 1'b0, 1'b0);
    word_row(pksd_pkg::ACT_CLEAR, 32'h0A00_0001, 16'd500, 1'b1, 1'b0);
    word_row(pksd_pkg::ACT_KNOCK, 32'h0A00_0001, 16'd500, 1'b0, 1'b0);
    for (int j = 0; j < NUM_SEQ_REGS; j++)
      reg_row(CFG_IDX_W'(pksd_pkg::CFG_SEQ_PORT_0 + j), 16'hFFFF);
    for (int j = 0; j < SEQ_LEN_DEF; j++)
      word_row(pksd_pkg::ACT_KNOCK, 32'h0, 16'hFFFF, 1'b0, 1'b0);
    for (int j = 0; j < NUM_SEQ_REGS; j++)
      reg_row(CFG_IDX_W'(pksd_pkg::CFG_SEQ_PORT_0 + j), 16'h0000);
    word_row(pksd_pkg::ACT_KNOCK, 32'h0000_0000, 16'hFFFF, 1'b0, 1'b0);
    word_row(pksd_pkg::ACT_KNOCK, 32'h0000_0001, 16'h0000, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settings = 1;

    for (int r = 0; r < dir_rows.size(); r++) begin
      if (dir_rows[r].kind == ROW_REG) begin
        if (r == 0 || dir_rows[r - 1].kind != ROW_REG) begin
          drain_words();
          settings++;
        end
        write_reg(dir_rows[r].idx, dir_rows[r].port);
        if (r + 1 == dir_rows.size() || dir_rows[r + 1].kind != ROW_REG) cfg_valid <= 1'b0;
      end else begin
        send_word(dir_rows[r].act, dir_rows[r].addr, dir_rows[r].port,
                  dir_rows[r].typed, dir_rows[r].want);
      end
    end

    base = knocks_sent + clears_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      addr_pool = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
      for (int j = 0; j < NUM_SEQ_REGS; j++) begin
        case (ph)
          0: ports[j] = 16'($urandom);
          1: ports[j] = 16'hFFFF;
          2: ports[j] = 16'h0000;
          default: begin
            case ($urandom_range(0, 3))
              0: ports[j] = 16'h0000;
              1: ports[j] = 16'hFFFF;
              2: ports[j] = 16'($urandom);
              default: ports[j] = (j == 0) ? 16'($urandom) : ports[j - 1];
            endcase
          end
        endcase
      end
      load_ports(ports);
      calm = (ph == 1);  // one full phase with no stalls on either side
      while (rand_words - base < (ph + 1) * RAND_WORDS / PHASES) random_episode();
    end

    drain_words();
    $display("Covered %0d knocks and %0d history clears over %0d port settings;",
             knocks_sent, clears_sent, settings);
    $display("%0d words completed the knock sequence.", hits);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
